[hw/rtl/nvme_queue_pair_engine_unit_macros.svh]
// Assertion macros shared by the queue pair engine RTL.
`ifndef NVME_QUEUE_PAIR_ENGINE_UNIT_MACROS_SVH
`define NVME_QUEUE_PAIR_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define QPE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue pair engine check failed");
// Next-cycle implication, checked out of reset.
`define QPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue pair engine check failed");
`else
`define QPE_ASSERT_NOW(label, clk, rst, ante, cons)
`define QPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/nvme_qpe_pkg.sv]
// Types and constants shared by the queue pair engine modules.
`timescale 1ns / 1ps
`default_nettype none
package nvme_qpe_pkg;

  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_POLL   = 1'b1;

  localparam logic QUEUE_ADMIN = 1'b0;
  localparam logic QUEUE_IO    = 1'b1;

  localparam int LIMIT_W  = 20;
  localparam int CID_W    = 16;
  localparam int SLOT_W   = 6;
  localparam logic [LIMIT_W-1:0] POLL_LIMIT_RESET = 20'd500000;

  typedef enum logic [1:0] {
    KIND_SUBMIT  = 2'd0,
    KIND_OK      = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_TIMEOUT = 2'd3
  } result_kind_t;

  typedef struct packed {
    logic             func;
    logic             queue_sel;
    logic [7:0]       opcode;
    logic [31:0]      namespace_id;
    logic [63:0]      data_pointer;
    logic [31:0]      command_dw10;
    logic [31:0]      command_dw11;
    logic [31:0]      command_dw12;
    logic [15:0]      entry_status;
    logic [CID_W-1:0] entry_cid;
  } cmd_t;

  typedef struct packed {
    result_kind_t      result_kind;
    logic              queue_out;
    logic [SLOT_W-1:0] sq_slot;
    logic [31:0]       entry_dw0;
    logic [31:0]       entry_nsid;
    logic [63:0]       entry_prp1;
    logic [31:0]       entry_dw10;
    logic [31:0]       entry_dw11;
    logic [31:0]       entry_dw12;
    logic [SLOT_W-1:0] doorbell_value;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/nvme_qpe_ctrl.sv]
// Queue pointers, command id tracking and completion matching for one item.
`timescale 1ns / 1ps
`default_nettype none
module nvme_qpe_ctrl #(
  parameter int ADMIN_DEPTH = 32,
  parameter int IO_DEPTH    = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              fire,
  input  wire nvme_qpe_pkg::cmd_t                cmd,
  input  wire logic                              cfg_we,
  input  wire logic [nvme_qpe_pkg::LIMIT_W-1:0]  cfg_data,
  output nvme_qpe_pkg::result_t                  res,
  output logic                                   res_valid
);

  localparam int MAX_DEPTH = (ADMIN_DEPTH > IO_DEPTH) ? ADMIN_DEPTH : IO_DEPTH;
  localparam int PW = $clog2(MAX_DEPTH);
  localparam int SW = nvme_qpe_pkg::SLOT_W;
  localparam logic [PW-1:0] ADMIN_LAST = PW'(ADMIN_DEPTH - 1);
  localparam logic [PW-1:0] IO_LAST    = PW'(IO_DEPTH - 1);

  logic [nvme_qpe_pkg::LIMIT_W-1:0] poll_limit;
  logic [nvme_qpe_pkg::CID_W-1:0]   cid_counter;
  logic [PW-1:0]                    sub_tail [2];
  logic [PW-1:0]                    comp_head [2];
  logic [1:0]                       expected_phase;
  logic                             waiting;
  logic [nvme_qpe_pkg::CID_W-1:0]   expected_cid;
  logic                             waiting_queue;
  logic [nvme_qpe_pkg::LIMIT_W-1:0] poll_budget;

  logic                             q;
  logic                             is_submit;
  logic [PW-1:0]                    last;
  logic [PW-1:0]                    tail_next;
  logic [PW-1:0]                    head_next;
  logic [nvme_qpe_pkg::CID_W-1:0]   cid_next;
  logic                             match;
  logic                             timeout;
  logic [PW+SW-1:0]                 slot_ext;
  logic [PW+SW-1:0]                 tail_ext;
  logic [PW+SW-1:0]                 head_ext;

  // A poll always concerns the queue whose command is awaited.
  assign is_submit = (cmd.func == nvme_qpe_pkg::FUNC_SUBMIT);
  assign q         = is_submit ? cmd.queue_sel : waiting_queue;
  assign last      = (q == nvme_qpe_pkg::QUEUE_IO) ? IO_LAST : ADMIN_LAST;
  assign tail_next = (sub_tail[q] == last) ? '0 : sub_tail[q] + PW'(1);
  assign head_next = (comp_head[q] == last) ? '0 : comp_head[q] + PW'(1);
  assign cid_next  = cid_counter + nvme_qpe_pkg::CID_W'(1);
  assign match     = (cmd.entry_status[0] == expected_phase[q]) &&
                     (cmd.entry_cid == expected_cid);
  assign timeout   = !match && (poll_budget <= nvme_qpe_pkg::LIMIT_W'(1));

  // Slot and doorbell show the low bits of a pointer, zero extended if narrow.
  assign slot_ext = {{SW{1'b0}}, sub_tail[q]};
  assign tail_ext = {{SW{1'b0}}, tail_next};
  assign head_ext = {{SW{1'b0}}, head_next};

  always_comb begin
    res           = '0;
    res.queue_out = q;
    res_valid     = 1'b0;
    if (is_submit) begin
      res_valid          = 1'b1;
      res.result_kind    = nvme_qpe_pkg::KIND_SUBMIT;
      res.sq_slot        = slot_ext[SW-1:0];
      res.entry_dw0      = {cid_next, 8'h00, cmd.opcode};
      res.entry_nsid     = cmd.namespace_id;
      res.entry_prp1     = cmd.data_pointer;
      res.entry_dw10     = cmd.command_dw10;
      res.entry_dw11     = cmd.command_dw11;
      res.entry_dw12     = cmd.command_dw12;
      res.doorbell_value = tail_ext[SW-1:0];
    end else if (waiting) begin
      if (match) begin
        res_valid          = 1'b1;
        res.result_kind    = (|cmd.entry_status[11:1]) ? nvme_qpe_pkg::KIND_ERROR
                                                       : nvme_qpe_pkg::KIND_OK;
        res.doorbell_value = head_ext[SW-1:0];
      end else if (timeout) begin
        res_valid       = 1'b1;
        res.result_kind = nvme_qpe_pkg::KIND_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit     <= nvme_qpe_pkg::POLL_LIMIT_RESET;
      cid_counter    <= '0;
      sub_tail[0]    <= '0;
      sub_tail[1]    <= '0;
      comp_head[0]   <= '0;
      comp_head[1]   <= '0;
      expected_phase <= 2'b11;
      waiting        <= 1'b0;
      expected_cid   <= '0;
      waiting_queue  <= 1'b0;
      poll_budget    <= '0;
    end else begin
      if (cfg_we) begin
        poll_limit <= cfg_data;
      end
      if (fire) begin
        if (is_submit) begin
          cid_counter   <= cid_next;
          sub_tail[q]   <= tail_next;
          waiting       <= 1'b1;
          expected_cid  <= cid_next;
          waiting_queue <= q;
          poll_budget   <= poll_limit;
        end else if (waiting) begin
          if (match) begin
            comp_head[q] <= head_next;
            if (head_next == '0) begin
              expected_phase[q] <= ~expected_phase[q];
            end
            waiting <= 1'b0;
          end else if (timeout) begin
            poll_budget <= '0;
            waiting     <= 1'b0;
          end else begin
            poll_budget <= poll_budget - nvme_qpe_pkg::LIMIT_W'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/nvme_qpe_out.sv]
// Result register that holds one finished item until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module nvme_qpe_out (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire nvme_qpe_pkg::result_t res_in,
  input  wire logic                  take,
  output logic                       valid,
  output nvme_qpe_pkg::result_t      res
);

  logic valid_next;

  // A load happens only while the register is empty or being emptied.
  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/nvme_queue_pair_engine_unit.sv]
// Top level of the NVMe queue pair engine: input register, control and result register.
//
// Usage: the host side streams items on the s_axis channel. A submit item
// (tuser func = 0) carries the command words; the engine assigns the next
// command id, returns the packed submission entry with its slot and the new
// submission tail to ring. A poll item (func = 1) carries the completion
// entry read at the head of the queue whose command is awaited; a matching
// entry returns ok or error plus the new completion head, and a run of
// non-matching polls ends in a timeout result once the poll budget is spent.
// A poll while no command is awaited, or a non-matching poll with budget
// left, produces no result. The cfg channel writes the 20-bit poll limit and
// is always ready; write it only while the engine is idle.
// Flow: an item is registered at the input and evaluated in one pass; its
// result is loaded into the output register when the item fires, and the
// output register holds it, with m_axis_tvalid high, until the receiver takes it.
// Throughput: one item per cycle unless the receiver stalls; the pointer and id
// updates are a single increment-and-wrap per queue, closing in the evaluation cycle.
// Reset (rst, synchronous) clears pointers, the id counter and the wait
// state, sets both expected phases to one and the poll limit to 500000.
// When the receiver stalls, the result register holds its item, the input
// register fills, and s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "nvme_queue_pair_engine_unit_macros.svh"
module nvme_queue_pair_engine_unit #(
  parameter int ADMIN_DEPTH = 32,
  parameter int IO_DEPTH    = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode, namespace_id, data_pointer, command_dw10, command_dw11,
  // command_dw12, entry_status, entry_cid (lowest bit first)
  input  wire logic [231:0] s_axis_tdata,
  // func, queue_sel (lowest bit first)
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // sq_slot, entry_dw0, entry_nsid, entry_prp1, entry_dw10, entry_dw11,
  // entry_dw12, doorbell_value (lowest bit first), then four zero bits
  output logic [239:0]      m_axis_tdata,
  // result_kind, queue_out (lowest bit first)
  output logic [2:0]        m_axis_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [19:0]  cfg_data
);

  logic                  in_valid;
  logic                  in_valid_next;
  nvme_qpe_pkg::cmd_t    cmd;
  logic                  s_accept;
  logic                  fire;
  nvme_qpe_pkg::result_t res_comb;
  logic                  res_comb_valid;
  nvme_qpe_pkg::result_t res;

  // The registered item is evaluated whenever the result register can take
  // whatever it produces; the input register refills in the same cycle.
  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_comb begin
    in_valid_next = in_valid;
    if (s_accept) begin
      in_valid_next = 1'b1;
    end else if (fire) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      cmd.func         <= s_axis_tuser[0];
      cmd.queue_sel    <= s_axis_tuser[1];
      cmd.opcode       <= s_axis_tdata[7:0];
      cmd.namespace_id <= s_axis_tdata[39:8];
      cmd.data_pointer <= s_axis_tdata[103:40];
      cmd.command_dw10 <= s_axis_tdata[135:104];
      cmd.command_dw11 <= s_axis_tdata[167:136];
      cmd.command_dw12 <= s_axis_tdata[199:168];
      cmd.entry_status <= s_axis_tdata[215:200];
      cmd.entry_cid    <= s_axis_tdata[231:216];
    end
  end

  nvme_qpe_ctrl #(
    .ADMIN_DEPTH (ADMIN_DEPTH),
    .IO_DEPTH    (IO_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res       (res_comb),
    .res_valid (res_comb_valid)
  );

  nvme_qpe_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (fire && res_comb_valid),
    .res_in (res_comb),
    .take   (m_axis_tready),
    .valid  (m_axis_tvalid),
    .res    (res)
  );

  assign m_axis_tuser = {res.queue_out, res.result_kind};
  assign m_axis_tdata = {4'b0000, res.doorbell_value, res.entry_dw12, res.entry_dw11,
                         res.entry_dw10, res.entry_prp1, res.entry_nsid,
                         res.entry_dw0, res.sq_slot};

  // Every submit that is evaluated leaves a result in the output register.
  `QPE_ASSERT_NEXT(a_submit_gives_result, clk, rst,
    fire && (cmd.func == nvme_qpe_pkg::FUNC_SUBMIT), m_axis_tvalid)
  // The input side only backs up when both stages are full and stalled.
  `QPE_ASSERT_NOW(a_ready_low_only_when_full, clk, rst,
    !s_axis_tready, in_valid && m_axis_tvalid && !m_axis_tready)
  // A timeout rings no doorbell.
  `QPE_ASSERT_NOW(a_timeout_no_doorbell, clk, rst,
    m_axis_tvalid && (m_axis_tuser[1:0] == nvme_qpe_pkg::KIND_TIMEOUT),
    m_axis_tdata[235:230] == 6'd0)

endmodule
`default_nettype wire
